FILE: hdl/mpool_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared constants, types and helpers for the streaming 2D max-pool block.
// ----------------------------------------------------------------------------
package mpool_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int PIXEL_BITS = 16;

    // register field widths
    localparam int CH_W      = 11;
    localparam int H_W       = 13;
    localparam int W_W       = 6;
    localparam int K_W       = 4;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PCC_W     = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W     = 8;
    localparam int REM_STEPS = H_W;
    localparam int REM_CNT_W = $clog2(REM_STEPS);

    typedef logic signed [PIXEL_BITS-1:0] pixel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS  = 3'd0,
        CFG_IN_HEIGHT = 3'd1,
        CFG_IN_WIDTH  = 3'd2,
        CFG_OUT_WIDTH = 3'd3,
        CFG_KERNEL_X  = 3'd4,
        CFG_KERNEL_Y  = 3'd5,
        CFG_STRIDE    = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RC_START,
        S_RC_WAIT,
        S_HORZ,
        S_VREAD,
        S_VCALC,
        S_ROWEND,
        S_FREAD,
        S_FEMIT,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic load_pixel;
        logic rem_start;
        logic rem_load;
        logic horz;
        logic v_read;
        logic v_skip;
        logic v_exec;
        logic row_end;
        logic f_read;
        logic f_exec;
        logic drain_push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic dirty;
        logic rem_busy;
        logic call_ok;
        logic call_is_last;
        logic exec_emits;
        logic pend_valid;
        logic out_free;
        logic flush_needed;
        logic flush_last;
    } dp_status_t;

    function automatic pixel_t pix_max(pixel_t a, pixel_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: hdl/mpool_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpool_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/mpool_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mpool_rem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mpool_pkg::H_W-1:0]  dividend,
    input  logic [mpool_pkg::K_W-1:0]  divisor,
    output logic                       busy,
    output logic [mpool_pkg::K_W-1:0]  remainder
);
    import mpool_pkg::*;

    logic                 busy_reg, busy_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic [H_W-1:0]       dvd_reg, dvd_next;
    logic [K_W-1:0]       dvs_reg, dvs_next;
    logic [K_W-1:0]       rem_reg, rem_next;
    logic [K_W:0]         shifted;
    logic [K_W:0]         diff;

    always_comb begin
        shifted   = {rem_reg, dvd_reg[H_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // partial remainder stays below the divisor, so it fits K_W bits
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = diff[K_W-1:0];
            end else begin
                rem_next = shifted[K_W-1:0];
            end
            dvd_next = {dvd_reg[H_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == REM_CNT_W'(REM_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/mpool_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_datapath
// Configuration registers, position counters, horizontal and vertical pooling
// arithmetic, line store and the result register.
// ----------------------------------------------------------------------------
module mpool_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mpool_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpool_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [mpool_pkg::PIXEL_BITS-1:0] s_pixel_value,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [mpool_pkg::PIXEL_BITS-1:0] m_pooled_value,
    output logic                             m_last_of_run,
    input  mpool_pkg::ctrl_cmd_t             cmd,
    output mpool_pkg::dp_status_t            status
);
    import mpool_pkg::*;

    // configuration
    logic [CH_W-1:0] channels_reg;
    logic [H_W-1:0]  in_height_reg;
    logic [W_W-1:0]  in_width_reg;
    logic [W_W-1:0]  out_width_reg;
    logic [K_W-1:0]  kernel_x_reg;
    logic [K_W-1:0]  kernel_y_reg;
    logic [K_W-1:0]  stride_reg;
    logic            dirty_reg, dirty_next;

    // position state
    logic [W_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [K_W-1:0]  col_rem_reg, col_rem_next;
    logic [H_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [K_W-1:0]  row_rem_reg, row_rem_next;
    logic [CH_W-1:0] chan_cnt_reg, chan_cnt_next;
    logic [PCC_W-1:0] pcc_reg, pcc_next;
    logic [ADDR_W-1:0] fc_reg, fc_next;

    // item work registers
    pixel_t pixel_reg, pixel_next;
    pixel_t rmax_reg, rmax_next;
    pixel_t call_val_reg [2];
    pixel_t call_val_next [2];
    logic [1:0] call_vld_reg, call_vld_next;
    logic       call_idx_reg, call_idx_next;

    // pending result and output register
    pixel_t pend_val_reg, pend_val_next;
    logic   pend_vld_reg, pend_vld_next;
    pixel_t out_val_reg, out_val_next;
    logic   out_last_reg, out_last_next;
    logic   out_vld_reg, out_vld_next;

    // derived
    logic [K_W-1:0]   kx, ky;
    logic             h_overlap, v_overlap;
    logic             last_col, row_more, chan_more, channel_end;
    logic             col_phase_end, row_phase_end;
    logic [CMP_W-1:0] lim;
    logic             pcc_in_range;
    pixel_t           cur_val, rd_pix, h_t, v_t;
    pixel_t           exec_value, exec_wdata;
    logic             exec_emits, exec_write;
    logic             out_free, push;

    // line store
    logic                  ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]     ram_wr_addr, ram_rd_addr;
    logic [PIXEL_BITS-1:0] ram_wr_data, ram_rd_data;

    // phase recompute
    logic           row_rem_busy, col_rem_busy;
    logic [K_W-1:0] row_rem_res, col_rem_res;

    mpool_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mpool_rem u_row_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (row_cnt_reg),
        .divisor   (ky),
        .busy      (row_rem_busy),
        .remainder (row_rem_res)
    );

    mpool_rem u_col_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (H_W'(col_cnt_reg)),
        .divisor   (kx),
        .busy      (col_rem_busy),
        .remainder (col_rem_res)
    );

    always_comb begin
        kx        = (kernel_x_reg == '0) ? K_W'(1) : kernel_x_reg;
        ky        = (kernel_y_reg == '0) ? K_W'(1) : kernel_y_reg;
        h_overlap = (kernel_x_reg != stride_reg);
        v_overlap = (kernel_y_reg != stride_reg);

        last_col    = (CMP_W'(col_cnt_reg) + CMP_W'(1)) >= CMP_W'(in_width_reg);
        row_more    = ({1'b0, row_cnt_reg} + 1'b1) < {1'b0, in_height_reg};
        chan_more   = ({1'b0, chan_cnt_reg} + 1'b1) < {1'b0, channels_reg};
        channel_end = last_col && !row_more;

        col_phase_end = ({1'b0, col_rem_reg} + 1'b1) == {1'b0, kx};
        row_phase_end = ({1'b0, row_rem_reg} + 1'b1) == {1'b0, ky};

        lim = (CMP_W'(out_width_reg) < CMP_W'(MAX_WIDTH)) ? CMP_W'(out_width_reg)
                                                           : CMP_W'(MAX_WIDTH);
        pcc_in_range = CMP_W'(pcc_reg) < lim;

        cur_val = call_val_reg[call_idx_reg];
        rd_pix  = ram_rd_data;

        h_t = (col_rem_reg == '0) ? pixel_reg : pix_max(rmax_reg, pixel_reg);
        v_t = (row_rem_reg == '0) ? cur_val : pix_max(rd_pix, cur_val);

        if (v_overlap) begin
            exec_emits = (row_cnt_reg != '0);
            exec_value = pix_max(rd_pix, cur_val);
            exec_write = 1'b1;
            exec_wdata = cur_val;
        end else begin
            exec_emits = row_phase_end;
            exec_value = v_t;
            exec_write = !row_phase_end;
            exec_wdata = v_t;
        end

        out_free = !out_vld_reg || m_ready;
    end

    // line store port muxing
    always_comb begin
        ram_rd_en   = cmd.v_read || cmd.f_read;
        ram_rd_addr = cmd.v_read ? pcc_reg[ADDR_W-1:0] : fc_reg;
        ram_wr_en   = (cmd.v_exec && exec_write) || cmd.f_exec;
        ram_wr_addr = cmd.v_exec ? pcc_reg[ADDR_W-1:0] : fc_reg;
        ram_wr_data = cmd.v_exec ? exec_wdata : '0;
    end

    always_comb begin
        dirty_next       = dirty_reg;
        col_cnt_next     = col_cnt_reg;
        col_rem_next     = col_rem_reg;
        row_cnt_next     = row_cnt_reg;
        row_rem_next     = row_rem_reg;
        chan_cnt_next    = chan_cnt_reg;
        pcc_next         = pcc_reg;
        fc_next          = fc_reg;
        pixel_next       = pixel_reg;
        rmax_next        = rmax_reg;
        call_val_next[0] = call_val_reg[0];
        call_val_next[1] = call_val_reg[1];
        call_vld_next    = call_vld_reg;
        call_idx_next    = call_idx_reg;
        pend_val_next    = pend_val_reg;
        pend_vld_next    = pend_vld_reg;
        out_val_next     = out_val_reg;
        out_last_next    = out_last_reg;
        push             = 1'b0;

        if (cmd.rem_start) begin
            dirty_next = 1'b0;
        end
        if (cfg_wr_en) begin
            dirty_next = 1'b1;
        end
        if (cmd.rem_load) begin
            row_rem_next = row_rem_res;
            col_rem_next = col_rem_res;
        end

        if (cmd.load_pixel) begin
            pixel_next = s_pixel_value;
        end

        if (cmd.horz) begin
            call_idx_next = 1'b0;
            if (h_overlap) begin
                call_vld_next    = {last_col, (col_cnt_reg != '0)};
                call_val_next[0] = pix_max(rmax_reg, pixel_reg);
                call_val_next[1] = pix_max(pixel_reg, '0);
                rmax_next        = pixel_reg;
            end else begin
                call_vld_next    = {1'b0, col_phase_end};
                call_val_next[0] = h_t;
                if (!col_phase_end) begin
                    rmax_next = h_t;
                end
            end
        end

        if (cmd.v_skip) begin
            call_idx_next = !call_idx_reg;
        end

        if (cmd.v_exec) begin
            call_idx_next = !call_idx_reg;
            pcc_next      = pcc_reg + 1'b1;
            if (exec_emits) begin
                // older pending result is not the last one of this transfer run
                if (pend_vld_reg) begin
                    push          = 1'b1;
                    out_val_next  = pend_val_reg;
                    out_last_next = 1'b0;
                end
                pend_val_next = exec_value;
                pend_vld_next = 1'b1;
            end
        end

        if (cmd.row_end) begin
            fc_next  = '0;
            if (!last_col) begin
                col_cnt_next = col_cnt_reg + 1'b1;
                col_rem_next = col_phase_end ? '0 : col_rem_reg + 1'b1;
            end else begin
                pcc_next     = '0;
                col_cnt_next = '0;
                col_rem_next = '0;
                if (row_more) begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                    row_rem_next = row_phase_end ? '0 : row_rem_reg + 1'b1;
                end else begin
                    row_cnt_next  = '0;
                    row_rem_next  = '0;
                    chan_cnt_next = chan_more ? chan_cnt_reg + 1'b1 : '0;
                end
            end
        end

        if (cmd.f_exec) begin
            fc_next = fc_reg + 1'b1;
            if (pend_vld_reg) begin
                push          = 1'b1;
                out_val_next  = pend_val_reg;
                out_last_next = 1'b0;
            end
            pend_val_next = pix_max(rd_pix, '0);
            pend_vld_next = 1'b1;
        end

        if (cmd.drain_push) begin
            push          = 1'b1;
            out_val_next  = pend_val_reg;
            out_last_next = 1'b1;
            pend_vld_next = 1'b0;
        end

        if (push) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channels_reg  <= CH_W'(1);
            in_height_reg <= H_W'(2);
            in_width_reg  <= W_W'(2);
            out_width_reg <= W_W'(1);
            kernel_x_reg  <= K_W'(2);
            kernel_y_reg  <= K_W'(2);
            stride_reg    <= K_W'(2);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHANNELS:  channels_reg  <= cfg_wdata[CH_W-1:0];
                CFG_IN_HEIGHT: in_height_reg <= cfg_wdata[H_W-1:0];
                CFG_IN_WIDTH:  in_width_reg  <= cfg_wdata[W_W-1:0];
                CFG_OUT_WIDTH: out_width_reg <= cfg_wdata[W_W-1:0];
                CFG_KERNEL_X:  kernel_x_reg  <= cfg_wdata[K_W-1:0];
                CFG_KERNEL_Y:  kernel_y_reg  <= cfg_wdata[K_W-1:0];
                CFG_STRIDE:    stride_reg    <= cfg_wdata[K_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg    <= 1'b0;
            col_cnt_reg  <= '0;
            col_rem_reg  <= '0;
            row_cnt_reg  <= '0;
            row_rem_reg  <= '0;
            chan_cnt_reg <= '0;
            pcc_reg      <= '0;
            fc_reg       <= '0;
            rmax_reg     <= '0;
            call_vld_reg <= '0;
            call_idx_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            dirty_reg    <= dirty_next;
            col_cnt_reg  <= col_cnt_next;
            col_rem_reg  <= col_rem_next;
            row_cnt_reg  <= row_cnt_next;
            row_rem_reg  <= row_rem_next;
            chan_cnt_reg <= chan_cnt_next;
            pcc_reg      <= pcc_next;
            fc_reg       <= fc_next;
            rmax_reg     <= rmax_next;
            call_vld_reg <= call_vld_next;
            call_idx_reg <= call_idx_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
        pixel_reg       <= pixel_next;
        call_val_reg[0] <= call_val_next[0];
        call_val_reg[1] <= call_val_next[1];
        pend_val_reg    <= pend_val_next;
        out_val_reg     <= out_val_next;
        out_last_reg    <= out_last_next;
    end

    always_comb begin
        status.dirty        = dirty_reg;
        status.rem_busy     = row_rem_busy || col_rem_busy;
        status.call_ok      = call_vld_reg[call_idx_reg] && pcc_in_range;
        status.call_is_last = call_idx_reg;
        status.exec_emits   = exec_emits;
        status.pend_valid   = pend_vld_reg;
        status.out_free     = out_free;
        status.flush_needed = channel_end && v_overlap && (lim != '0);
        status.flush_last   = (CMP_W'(fc_reg) + CMP_W'(1)) >= lim;
    end

    assign m_valid        = out_vld_reg;
    assign m_pooled_value = out_val_reg;
    assign m_last_of_run  = out_last_reg;

endmodule

FILE: hdl/mpool_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_ctrl
// Sequencer that walks one pixel through horizontal pooling, line-store
// updates, end-of-row bookkeeping, channel flush and result drain.
// ----------------------------------------------------------------------------
module mpool_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mpool_pkg::dp_status_t status,
    output mpool_pkg::ctrl_cmd_t  cmd
);
    import mpool_pkg::*;

    state_t state_reg, state_next;
    logic   emit_stall, flush_stall;

    assign emit_stall  = status.exec_emits && status.pend_valid && !status.out_free;
    assign flush_stall = status.pend_valid && !status.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (status.dirty) begin
                    state_next = S_RC_START;
                end else if (s_valid) begin
                    state_next = S_HORZ;
                end
            end
            S_RC_START: state_next = S_RC_WAIT;
            S_RC_WAIT: begin
                if (!status.rem_busy) begin
                    state_next = S_IDLE;
                end
            end
            S_HORZ: state_next = S_VREAD;
            S_VREAD: begin
                if (status.call_ok) begin
                    state_next = S_VCALC;
                end else if (status.call_is_last) begin
                    state_next = S_ROWEND;
                end
            end
            S_VCALC: begin
                if (!emit_stall) begin
                    state_next = status.call_is_last ? S_ROWEND : S_VREAD;
                end
            end
            S_ROWEND: state_next = status.flush_needed ? S_FREAD : S_DRAIN;
            S_FREAD:  state_next = S_FEMIT;
            S_FEMIT: begin
                if (!flush_stall) begin
                    state_next = status.flush_last ? S_DRAIN : S_FREAD;
                end
            end
            S_DRAIN: begin
                if (!status.pend_valid || status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready        = !status.dirty;
                cmd.load_pixel = s_valid && !status.dirty;
            end
            S_RC_START: cmd.rem_start = 1'b1;
            S_RC_WAIT:  cmd.rem_load  = !status.rem_busy;
            S_HORZ:     cmd.horz      = 1'b1;
            S_VREAD: begin
                cmd.v_read = status.call_ok;
                cmd.v_skip = !status.call_ok;
            end
            S_VCALC:  cmd.v_exec  = !emit_stall;
            S_ROWEND: cmd.row_end = 1'b1;
            S_FREAD:  cmd.f_read  = 1'b1;
            S_FEMIT:  cmd.f_exec  = !flush_stall;
            S_DRAIN:  cmd.drain_push = status.pend_valid && status.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/max_pool_2d_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2D max pooling, top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
// Pixels arrive one per transfer in channel, row, column order and pooled
// pixels leave in the same order; m_last_of_run marks the last result caused
// by an input pixel. Each horizontally pooled value of a pixel that reaches
// the line store (at most two per pixel) is read and updated in separate
// states, since the line store has a single read port with registered data.
// On the last pixel of a channel in overlapping vertical mode the padded row
// is flushed with a read and an emit state per pooled column, for up to 32
// pooled columns. After any configuration write the row and column window
// phases are recomputed by a bit-serial remainder unit, which holds off the
// next pixel until it is done. A stalled result side holds the block once
// its single pending result and the output register are both full.
// ----------------------------------------------------------------------------
module max_pool_2d_stream (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mpool_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpool_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mpool_pkg::PIXEL_BITS-1:0] s_pixel_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mpool_pkg::PIXEL_BITS-1:0] m_pooled_value,
    output logic                             m_last_of_run
);
    import mpool_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    mpool_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    mpool_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_pixel_value  (s_pixel_value),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_pooled_value (m_pooled_value),
        .m_last_of_run  (m_last_of_run),
        .cmd            (ctrl_cmd),
        .status         (dp_status)
    );

    // one pixel in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a pixel is still in work");

    // stale window phases must never see a pixel
    a_phase_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_status.dirty |-> !s_ready)
        else $error("pixel accepted before window phases were recomputed");

    // a pending result only moves into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.v_exec && dp_status.exec_emits && dp_status.pend_valid)
            || ctrl_cmd.drain_push |-> dp_status.out_free)
        else $error("result register overwritten before transfer");

endmodule
